// ----- rtl/pbd_pkg.sv -----
// pbd_pkg: shared types and constants of the PCI BAR decode block.
// No dependencies; imported by the interfaces, the decode unit and the top level.
`default_nettype none

package pbd_pkg;

  localparam int unsigned OFFSET_W   = 8;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned LEN_W      = 3;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned LG_W       = 6;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned KINDS_W    = 12;
  localparam int unsigned SIZES_W    = 42;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 42;

  // Region slots: six BARs plus the expansion ROM.
  localparam int unsigned MAX_REGIONS = 7;
  localparam int unsigned BAR_COUNT   = 6;
  localparam logic [IDX_W-1:0] ROM_SLOT = 3'd6;

  // Config-space offsets of interest.
  localparam logic [OFFSET_W-1:0] CMD_OFFSET  = 8'h04;
  localparam logic [OFFSET_W-1:0] BAR0_OFFSET = 8'h10;
  localparam logic [5:0]          ROM_DWORD   = 6'd8;   // dword 8 relative to BAR0, offset 0x30

  // BAR kind codes; code 3 decodes as mem32.
  localparam logic [KIND_W-1:0] KIND_MEM32 = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MEM64 = 2'd1;
  localparam logic [KIND_W-1:0] KIND_IO    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BAR_KINDS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAR_SIZES = 1'd1;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [KIND_W-1:0] kind;
    logic [LG_W-1:0]   lg;
    logic [DATA_W-1:0] v_lo;
    logic [DATA_W-1:0] v_hi;
    logic              pair_ok;   // an upper slot exists for a mem64 pairing
    logic              io_en;     // command bit 0
    logic              mem_en;    // command bit 1
    logic [ADDR_W-1:0] old_base;
  } dec_req_t;

  typedef struct packed {
    logic              mapped;
    logic [ADDR_W-1:0] base;
    logic              changed;
  } dec_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/pbd_if.sv -----
// pbd_if: valid/ready channel interfaces of the PCI BAR decode block.
// Depends on pbd_pkg for field widths.
`default_nettype none

interface pbd_req_if
  import pbd_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] cfg_offset;
  logic [DATA_W-1:0]   write_data;
  logic [LEN_W-1:0]    access_bytes;

  modport source (output valid, cfg_offset, write_data, access_bytes, input ready);
  modport sink   (input valid, cfg_offset, write_data, access_bytes, output ready);
endinterface

interface pbd_rsp_if
  import pbd_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  bar_index;
  logic              mapped;
  logic [ADDR_W-1:0] region_base;
  logic              changed;
  logic              bus_master_enable;
  logic              last;

  modport source (output valid, bar_index, mapped, region_base, changed,
                  bus_master_enable, last, input ready);
  modport sink   (input valid, bar_index, mapped, region_base, changed,
                  bus_master_enable, last, output ready);
endinterface

interface pbd_cfg_if
  import pbd_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/pbd_decode_unit.sv -----
// pbd_decode_unit: decode of one region (type mask, mem64 pairing, size alignment).
// Depends on pbd_pkg; shared by every region under the top-level sequencer.
`default_nettype none

module pbd_decode_unit
  import pbd_pkg::*;
(
  input  var dec_req_t dec_in,
  output dec_rsp_t     dec_out
);

  logic              on;
  logic [ADDR_W-1:0] raw_base;
  logic [ADDR_W-1:0] size_mask;
  logic [ADDR_W-1:0] base;

  always_comb begin
    if (dec_in.idx == ROM_SLOT) begin
      on       = dec_in.mem_en & dec_in.v_lo[0];
      raw_base = {32'd0, dec_in.v_lo & 32'hFFFF_F800};
    end else if (dec_in.kind == KIND_IO) begin
      on       = dec_in.io_en;
      raw_base = {32'd0, dec_in.v_lo & ~32'd3};
    end else begin
      on       = dec_in.mem_en;
      raw_base = {((dec_in.kind == KIND_MEM64) && dec_in.pair_ok) ? dec_in.v_hi : 32'd0,
                  dec_in.v_lo & ~32'hF};
    end
  end

  assign size_mask = {ADDR_W{1'b1}} << dec_in.lg;
  assign base      = on ? (raw_base & size_mask) : {ADDR_W{1'b1}};

  assign dec_out.mapped  = on;
  assign dec_out.base    = base;
  assign dec_out.changed = (base != dec_in.old_base);

endmodule

`default_nettype wire

// ----- rtl/pci_bar_decode_core.sv -----
// pci_bar_decode_core: shadow of a PCI type-0 command register and BARs with decode.
// Depends on pbd_pkg, the channel interfaces in pbd_if and pbd_decode_unit.
//
// Usage:
//   req  - config-space write transfers (cfg_offset, write_data, access_bytes).
//   rsp  - decode results, one per registered region touched; last marks the
//          final result of a write. A write that decodes nothing gives none.
//   cfg  - register writes: index 0 bar_kinds, index 1 bar_size_log2s.
//          Always ready; write only while the block is idle.
// Timing: a write is taken while the sequencer is idle. A BAR or ROM write then
//   does a read-modify-write of the BAR store (merge read, merge write) and, for a
//   registered region, a store read and a decode before its result is offered. A write
//   that covers the command register walks the registered regions in index order,
//   each with a store read, then decode in the shared unit. req is ready again once
//   the last result is in the output register.
// Stall: a result waits in the output register while rsp.ready is low; the
//   walk holds in its decode step until the register is free.
// Reset: command and registers clear, BAR store reads as zero (valid bits),
//   every mapping becomes all ones (unmapped). No clearing pass is needed.
`default_nettype none

module pci_bar_decode_core
  import pbd_pkg::*;
#(
  parameter int unsigned NUM_REGIONS = 7
) (
  input  wire clk,
  input  wire rst,
  pbd_req_if.sink   req,
  pbd_rsp_if.source rsp,
  pbd_cfg_if.sink   cfg
);

  localparam int unsigned AW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_MERGE_RD = 5'b00010,
    ST_MERGE_WR = 5'b00100,
    ST_READ     = 5'b01000,
    ST_DECODE   = 5'b10000
  } state_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } find_t;

  // byte-lane merge of a 1, 2 or 4 byte write; other lengths leave the dword
  function automatic logic [DATA_W-1:0] merge_lanes(
    input logic [DATA_W-1:0] old,
    input logic [1:0]        off,
    input logic [DATA_W-1:0] data,
    input logic [LEN_W-1:0]  len
  );
    logic [DATA_W-1:0] res;
    res = old;
    if (len == 3'd4) begin
      res = data;
    end else if (len == 3'd1) begin
      res = (old & ~(32'h0000_00FF << {off, 3'b000}))
          | ((data & 32'h0000_00FF) << {off, 3'b000});
    end else if (len == 3'd2) begin
      res = (old & ~(32'h0000_FFFF << {off[1], 4'b0000}))
          | ((data & 32'h0000_FFFF) << {off[1], 4'b0000});
    end
    return res;
  endfunction

  // lowest registered region at or above start
  function automatic find_t find_from(
    input logic [MAX_REGIONS-1:0] mask,
    input logic [IDX_W-1:0]       start
  );
    find_t f;
    f = '0;
    for (int r = MAX_REGIONS - 1; r >= 0; r--) begin
      if (mask[r] && (IDX_W'(r) >= start)) begin
        f.found = 1'b1;
        f.idx   = IDX_W'(r);
      end
    end
    return f;
  endfunction

  // configuration registers
  logic [KINDS_W-1:0] bar_kinds;
  logic [SIZES_W-1:0] bar_size_log2s;

  // shadow state
  logic [DATA_W-1:0] command_value;
  logic [ADDR_W-1:0] mapped_bases [NUM_REGIONS];

  // BAR store: small memory, two registered read ports, valid bits for reset
  logic [DATA_W-1:0]      bar_mem [NUM_REGIONS];
  logic [NUM_REGIONS-1:0] bar_valid;
  logic [AW-1:0]          addr_a, addr_b;
  logic [DATA_W-1:0]      rd_a, rd_b;
  logic                   rd_a_ok, rd_b_ok;
  logic                   mem_we;
  logic [DATA_W-1:0]      mem_wd;
  logic [DATA_W-1:0]      val_a, val_b;

  // sequencer
  state_t              state;
  logic [IDX_W-1:0]    cur;
  logic                walk;
  logic [1:0]          lat_off;
  logic [DATA_W-1:0]   lat_data;
  logic [LEN_W-1:0]    lat_len;

  // output register
  logic              out_valid;
  logic [IDX_W-1:0]  out_index;
  logic              out_mapped;
  logic [ADDR_W-1:0] out_base;
  logic              out_changed;
  logic              out_bme;
  logic              out_last;

  // per-region fields of the configuration
  logic [LG_W-1:0]        lg_arr   [8];
  logic [KIND_W-1:0]      kind_arr [8];
  logic [MAX_REGIONS-1:0] reg_mask;

  always_comb begin
    for (int r = 0; r < 8; r++) begin
      lg_arr[r]   = '0;
      kind_arr[r] = KIND_MEM32;
    end
    for (int r = 0; r < MAX_REGIONS; r++) begin
      lg_arr[r] = bar_size_log2s[LG_W*r +: LG_W];
    end
    for (int r = 0; r < BAR_COUNT; r++) begin
      kind_arr[r] = bar_kinds[KIND_W*r +: KIND_W];
    end
    for (int r = 0; r < MAX_REGIONS; r++) begin
      reg_mask[r] = (r < NUM_REGIONS) && (lg_arr[r] != '0);
    end
  end

  // input classification
  logic              accept;
  logic [8:0]        end_off;
  logic              cmd_hit;
  logic [5:0]        slot_raw;
  logic [IDX_W-1:0]  slot;
  logic              slot_ok;
  find_t             first_reg;
  find_t             next_reg;
  logic [IDX_W-1:0]  cur_inc;
  logic              pair_ok;
  logic              out_free;

  assign accept   = req.valid && req.ready;
  assign end_off  = {1'b0, req.cfg_offset} + {6'd0, req.access_bytes};
  assign cmd_hit  = (req.cfg_offset <= CMD_OFFSET) && (end_off > {1'b0, CMD_OFFSET});
  // dword index relative to BAR0; only used at offsets of BAR0 and above
  assign slot_raw = req.cfg_offset[7:2] - 6'(BAR0_OFFSET >> 2);

  always_comb begin
    slot    = slot_raw[IDX_W-1:0];
    slot_ok = 1'b0;
    if (req.cfg_offset >= BAR0_OFFSET) begin
      if (slot_raw == ROM_DWORD) begin
        slot    = ROM_SLOT;
        slot_ok = ({1'b0, ROM_SLOT} < 4'(NUM_REGIONS));
      end else if (slot_raw < 6'(BAR_COUNT)) begin
        slot_ok = ({1'b0, slot_raw[IDX_W-1:0]} < 4'(NUM_REGIONS));
      end
    end
  end

  assign first_reg = find_from(reg_mask, '0);
  assign cur_inc   = cur + 3'd1;
  assign next_reg  = find_from(reg_mask, cur_inc);
  assign pair_ok   = ({1'b0, cur_inc} < 4'(BAR_COUNT)) && ({1'b0, cur_inc} < 4'(NUM_REGIONS));
  assign out_free  = !out_valid || rsp.ready;

  // memory ports
  always_comb begin
    addr_a = cur[AW-1:0];
    addr_b = pair_ok ? cur_inc[AW-1:0] : cur[AW-1:0];
    mem_we = (state == ST_MERGE_WR);
    mem_wd = merge_lanes(val_a, lat_off, lat_data, lat_len);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bar_mem[cur[AW-1:0]] <= mem_wd;
    end
    rd_a    <= bar_mem[addr_a];
    rd_b    <= bar_mem[addr_b];
    rd_a_ok <= bar_valid[addr_a];
    rd_b_ok <= bar_valid[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_valid <= '0;
    end else if (mem_we) begin
      bar_valid[cur[AW-1:0]] <= 1'b1;
    end
  end

  assign val_a = rd_a_ok ? rd_a : '0;
  assign val_b = rd_b_ok ? rd_b : '0;

  // shared decode unit
  dec_req_t dec_in;
  dec_rsp_t dec_out;

  always_comb begin
    dec_in.idx      = cur;
    dec_in.kind     = kind_arr[cur];
    dec_in.lg       = lg_arr[cur];
    dec_in.v_lo     = val_a;
    dec_in.v_hi     = val_b;
    dec_in.pair_ok  = pair_ok;
    dec_in.io_en    = command_value[0];
    dec_in.mem_en   = command_value[1];
    dec_in.old_base = mapped_bases[cur[AW-1:0]];
  end

  pbd_decode_unit u_decode (
    .dec_in  (dec_in),
    .dec_out (dec_out)
  );

  // configuration port
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_kinds      <= '0;
      bar_size_log2s <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_BAR_KINDS: bar_kinds      <= cfg.data[KINDS_W-1:0];
        REG_BAR_SIZES: bar_size_log2s <= cfg.data[SIZES_W-1:0];
      endcase
    end
  end

  // sequencer
  assign req.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (accept) begin
      lat_off  <= req.cfg_offset[1:0];
      lat_data <= req.write_data;
      lat_len  <= req.access_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cur           <= '0;
      walk          <= 1'b0;
      command_value <= '0;
      for (int r = 0; r < NUM_REGIONS; r++) begin
        mapped_bases[r] <= {ADDR_W{1'b1}};
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (cmd_hit) begin
              command_value <= merge_lanes(command_value, req.cfg_offset[1:0],
                                           req.write_data, req.access_bytes);
              walk <= 1'b1;
              cur  <= first_reg.idx;
              if (first_reg.found) begin
                state <= ST_READ;
              end
            end else if (slot_ok) begin
              walk  <= 1'b0;
              cur   <= slot;
              state <= ST_MERGE_RD;
            end
          end
        end
        ST_MERGE_RD: begin
          state <= ST_MERGE_WR;
        end
        ST_MERGE_WR: begin
          state <= reg_mask[cur] ? ST_READ : ST_IDLE;
        end
        ST_READ: begin
          state <= ST_DECODE;
        end
        ST_DECODE: begin
          if (out_free) begin
            mapped_bases[cur[AW-1:0]] <= dec_out.base;
            if (walk && next_reg.found) begin
              cur   <= next_reg.idx;
              state <= ST_READ;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DECODE) && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DECODE) && out_free) begin
      out_index   <= cur;
      out_mapped  <= dec_out.mapped;
      out_base    <= dec_out.base;
      out_changed <= dec_out.changed;
      out_bme     <= command_value[2];
      out_last    <= !(walk && next_reg.found);
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.bar_index         = out_index;
  assign rsp.mapped            = out_mapped;
  assign rsp.region_base       = out_base;
  assign rsp.changed           = out_changed;
  assign rsp.bus_master_enable = out_bme;
  assign rsp.last              = out_last;

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for pci_bar_decode_core (config write shadow and BAR decode).
// Depends on pbd_pkg, the channel interfaces in pbd_if and the core RTL; needs no files.

module tb_top;
  import pbd_pkg::*;

  localparam int unsigned NUM_REGIONS = 7;
  localparam int unsigned QUIET_LIMIT = 2000;  // cycles with no transfer on any channel
  localparam int unsigned SETTLE_CYCLES = 24;  // covers writes that decode nothing
  localparam logic [KIND_W-1:0] KIND_ALIAS = 2'd3;  // reserved code, decodes as mem32

  // How a stimulus row is checked: by the bench's own decode model, as giving no
  // result, or against a value typed into the table.
  typedef enum logic [1:0] {BY_MODEL, NO_RESULT, ONE_RESULT} row_chk_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic              mapped;
    logic [ADDR_W-1:0] base;
    logic              changed;
    logic              bme;
    logic              last;
  } bar_result_t;

  typedef struct packed {
    row_chk_t    chk;
    bar_result_t res;
  } plan_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] off;
    logic [DATA_W-1:0]   data;
    logic [LEN_W-1:0]    len;
    row_chk_t            chk;
    logic [IDX_W-1:0]    idx;
    logic                mapped;
    logic [ADDR_W-1:0]   base;
    logic                changed;
    logic                bme;
  } row_t;

  // Directed rows, run with the kinds/sizes set up below:
  // BAR0 mem32 4K, BAR1 mem64 1M (BAR2 is its upper half, registered 16B),
  // BAR3 io 256B, BAR4 reserved kind 2^63, BAR5 mem64 with no upper slot, ROM 2K.
  localparam row_t STIM_TABLE [0:25] = '{
    // sizing-style write while command is zero: stays unmapped, no change
    '{8'h10, 32'hFFFF_FFFF, 3'd4, ONE_RESULT, 3'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
    // CardBus and subsystem dwords are not BARs
    '{8'h28, 32'h1234_5678, 3'd4, NO_RESULT, 3'd0, 1'b0, 64'h0, 1'b0, 1'b0},
    '{8'h2C, 32'h1234_5678, 3'd4, NO_RESULT, 3'd0, 1'b0, 64'h0, 1'b0, 1'b0},
    // header dwords that miss the command register
    '{8'h08, 32'hFFFF_FFFF, 3'd4, NO_RESULT, 3'd0, 1'b0, 64'h0, 1'b0, 1'b0},
    '{8'h00, 32'hFFFF_FFFF, 3'd4, NO_RESULT, 3'd0, 1'b0, 64'h0, 1'b0, 1'b0},
    // capability pointer area, past the ROM slot
    '{8'h34, 32'hFFFF_FFFF, 3'd4, NO_RESULT, 3'd0, 1'b0, 64'h0, 1'b0, 1'b0},
    // three-byte access merges nothing but still decodes the slot
    '{8'h20, 32'hFFFF_FFFF, 3'd3, ONE_RESULT, 3'd4, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
    // enable io, mem and bus master: full walk
    '{8'h04, 32'h0000_0007, 3'd2, BY_MODEL, 3'd0, 1'b0, 64'h0, 1'b0, 1'b0},
    '{8'h10, 32'h1234_5678, 3'd4, BY_MODEL, 3'd0, 1'b0, 64'h0, 1'b0, 1'b0},
    '{8'h14, 32'hFFF0_000C, 3'd4, BY_MODEL, 3'd0, 1'b0, 64'h0, 1'b0, 1'b0},
    // upper half of the BAR1 pair: only slot 2 decodes
    '{8'h18, 32'hDEAD_BEEF, 3'd4, BY_MODEL, 3'd0, 1'b0, 64'h0, 1'b0, 1'b0},
    '{8'h14, 32'h0000_0055, 3'd1, BY_MODEL, 3'd0, 1'b0, 64'h0, 1'b0, 1'b0},
    '{8'h17, 32'hAB00_0000, 3'd1, BY_MODEL, 3'd0, 1'b0, 64'h0, 1'b0, 1'b0},
    '{8'h16, 32'h1234_0000, 3'd2, BY_MODEL, 3'd0, 1'b0, 64'h0, 1'b0, 1'b0},
    '{8'h1C, 32'hFFFF_FFFF, 3'd4, BY_MODEL, 3'd0, 1'b0, 64'h0, 1'b0, 1'b0},
    // 2^63 region: every address bit below 63 is cleared
    '{8'h20, 32'h8000_0000, 3'd4, ONE_RESULT, 3'd4, 1'b1, 64'h0, 1'b0, 1'b1},
    // mem64 in the last BAR has no upper slot
    '{8'h24, 32'hFFFF_FFFF, 3'd4, BY_MODEL, 3'd0, 1'b0, 64'h0, 1'b0, 1'b0},
    // ROM with and without its enable bit
    '{8'h30, 32'hFFFF_F801, 3'd4, BY_MODEL, 3'd0, 1'b0, 64'h0, 1'b0, 1'b0},
    '{8'h30, 32'hFFFF_F800, 3'd4, BY_MODEL, 3'd0, 1'b0, 64'h0, 1'b0, 1'b0},
    // misaligned accesses that still cover the command register
    '{8'h02, 32'hFFFF_FFFB, 3'd4, BY_MODEL, 3'd0, 1'b0, 64'h0, 1'b0, 1'b0},
    '{8'h03, 32'hFFFF_5A5A, 3'd2, BY_MODEL, 3'd0, 1'b0, 64'h0, 1'b0, 1'b0},
    '{8'h04, 32'h0000_0000, 3'd3, BY_MODEL, 3'd0, 1'b0, 64'h0, 1'b0, 1'b0},
    // zero length touches nothing
    '{8'h04, 32'h0000_0000, 3'd0, NO_RESULT, 3'd0, 1'b0, 64'h0, 1'b0, 1'b0},
    '{8'h04, 32'hFFFF_FFFF, 3'd7, BY_MODEL, 3'd0, 1'b0, 64'h0, 1'b0, 1'b0},
    '{8'hFF, 32'hFFFF_FFFF, 3'd1, NO_RESULT, 3'd0, 1'b0, 64'h0, 1'b0, 1'b0},
    '{8'h04, 32'h0000_0003, 3'd1, BY_MODEL, 3'd0, 1'b0, 64'h0, 1'b0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  pbd_req_if req_ch ();
  pbd_rsp_if rsp_ch ();
  pbd_cfg_if cfg_ch ();

  pci_bar_decode_core #(
    .NUM_REGIONS(NUM_REGIONS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  // Shadow of the block: stored BAR/ROM dwords, command, current mappings, registers.
  logic [DATA_W-1:0]  slot_vals [NUM_REGIONS];
  logic [ADDR_W-1:0]  live_bases [NUM_REGIONS];
  logic [DATA_W-1:0]  cmd_shadow;
  logic [KINDS_W-1:0] kinds_shadow;
  logic [SIZES_W-1:0] sizes_shadow;

  bar_result_t fresh_q[$];     // decodes caused by the write just taken
  bar_result_t decode_q[$];    // decodes still owed by the block
  plan_t       row_plan_q[$];  // one entry per write driven, popped on its transfer

  int unsigned fails = 0;
  int unsigned writes_taken = 0;
  int unsigned writes_hit = 0;
  int unsigned decodes_seen = 0;
  int unsigned settings_used = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned ready_ctr = 0;
  int unsigned stall_left = 0;

  initial begin
    for (int k = 0; k < NUM_REGIONS; k++) begin
      slot_vals[k] = '0;
      live_bases[k] = '1;
    end
    cmd_shadow = '0;
    kinds_shadow = '0;
    sizes_shadow = '0;
  end

  // Byte-lane merge of a config write into a stored dword. Lengths other than
  // 1, 2 and 4 leave the dword alone.
  function automatic logic [DATA_W-1:0] byte_merge(input logic [DATA_W-1:0] old,
                                                   input logic [OFFSET_W-1:0] off,
                                                   input logic [DATA_W-1:0] wd,
                                                   input logic [LEN_W-1:0] len);
    int unsigned sh;
    logic [DATA_W-1:0] m;
    if (len == 3'd4) return wd;
    if (len == 3'd1 || len == 3'd2) begin
      sh = (int'(off) & (4 - int'(len))) * 8;
      m = (len == 3'd1) ? 32'h0000_00FF : 32'h0000_FFFF;
      return (old & ~(m << sh)) | ((wd & m) << sh);
    end
    return old;
  endfunction

  // Decode one slot into fresh_q and record its new mapping; unregistered slots
  // produce nothing.
  function automatic void decode_slot(input int unsigned i);
    logic [LG_W-1:0]   lg;
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] base;
    logic              on;
    bar_result_t       r;
    lg = sizes_shadow[LG_W*i +: LG_W];
    if (lg == '0) return;
    if (i == ROM_SLOT) begin
      on = cmd_shadow[1] & slot_vals[i][0];
      base = {32'h0, slot_vals[i] & 32'hFFFF_F800};
    end else begin
      kind = kinds_shadow[KIND_W*i +: KIND_W];
      if (kind == KIND_IO) begin
        on = cmd_shadow[0];
        base = {32'h0, slot_vals[i] & ~32'h3};
      end else begin
        on = cmd_shadow[1];
        base = {32'h0, slot_vals[i] & ~32'hF};
        if (kind == KIND_MEM64 && i + 1 < BAR_COUNT && i + 1 < NUM_REGIONS)
          base[63:32] = slot_vals[i + 1];
      end
    end
    if (on) base = base & ~((64'd1 << lg) - 64'd1);
    else base = '1;
    r.idx = IDX_W'(i);
    r.mapped = on;
    r.base = base;
    r.changed = (base != live_bases[i]);
    r.bme = cmd_shadow[2];
    r.last = 1'b0;
    live_bases[i] = base;
    fresh_q.push_back(r);
  endfunction

  // Apply one accepted config write to the shadow. Returns 1 when the write
  // reached the command register or a BAR/ROM slot.
  function automatic bit apply_cfg_write(input logic [OFFSET_W-1:0] off,
                                         input logic [DATA_W-1:0] wd,
                                         input logic [LEN_W-1:0] len);
    int unsigned slot;
    bit hit;
    bar_result_t r;
    hit = 1'b0;
    fresh_q.delete();
    if (off <= CMD_OFFSET && int'(CMD_OFFSET) < int'(off) + int'(len)) begin
      cmd_shadow = byte_merge(cmd_shadow, off, wd, len);
      for (int unsigned i = 0; i < NUM_REGIONS; i++) decode_slot(i);
      hit = 1'b1;
    end else if (off >= BAR0_OFFSET) begin
      slot = (int'(off) - int'(BAR0_OFFSET)) / 4;
      if (slot == ROM_DWORD) slot = ROM_SLOT;
      else if (slot >= BAR_COUNT) slot = NUM_REGIONS;
      if (slot < NUM_REGIONS) begin
        slot_vals[slot] = byte_merge(slot_vals[slot], off, wd, len);
        decode_slot(slot);
        hit = 1'b1;
      end
    end
    if (fresh_q.size() > 0) begin
      r = fresh_q.pop_back();
      r.last = 1'b1;
      fresh_q.push_back(r);
    end
    return hit;
  endfunction

  // Monitor: every transfer on the three channels is seen here at the clock edge,
  // before the block's registers move.
  always @(posedge clk) begin
    plan_t plan;
    bar_result_t want;
    bar_result_t got;
    bit bad;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_BAR_KINDS) kinds_shadow = cfg_ch.data[KINDS_W-1:0];
        else sizes_shadow = cfg_ch.data[SIZES_W-1:0];
      end
      if (req_ch.valid && req_ch.ready) begin
        plan = row_plan_q.pop_front();
        writes_taken++;
        if (apply_cfg_write(req_ch.cfg_offset, req_ch.write_data, req_ch.access_bytes))
          writes_hit++;
        // Typed rows override the model's expectation; the shadow still advances.
        if (plan.chk == BY_MODEL) begin
          foreach (fresh_q[k]) decode_q.push_back(fresh_q[k]);
        end else if (plan.chk == ONE_RESULT) begin
          decode_q.push_back(plan.res);
        end
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        decodes_seen++;
        got.idx = rsp_ch.bar_index;
        got.mapped = rsp_ch.mapped;
        got.base = rsp_ch.region_base;
        got.changed = rsp_ch.changed;
        got.bme = rsp_ch.bus_master_enable;
        got.last = rsp_ch.last;
        if (decode_q.size() == 0) begin
          $error("unexpected decode transfer: bar_index %0d base %h", got.idx, got.base);
          fails++;
        end else begin
          want = decode_q.pop_front();
          bad = 1'b0;
          if (got.idx !== want.idx) begin
            $error("bar_index: expected %0d, got %0d", want.idx, got.idx);
            bad = 1'b1;
          end
          if (got.mapped !== want.mapped) begin
            $error("mapped: expected %0d, got %0d", want.mapped, got.mapped);
            bad = 1'b1;
          end
          if (got.base !== want.base) begin
            $error("region_base: expected %h, got %h", want.base, got.base);
            bad = 1'b1;
          end
          if (got.changed !== want.changed) begin
            $error("changed: expected %0d, got %0d", want.changed, got.changed);
            bad = 1'b1;
          end
          if (got.bme !== want.bme) begin
            $error("bus_master_enable: expected %0d, got %0d", want.bme, got.bme);
            bad = 1'b1;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            bad = 1'b1;
          end
          if (bad) fails++;
        end
      end
    end
  end

  // Result side back-pressure: the mode follows a free-running counter and moves between always
  // ready, light random stalls, runs of stalls and coin flips.
  always @(posedge clk) begin
    ready_ctr++;
    case (ready_ctr[7:6])
      2'd0: rsp_ch.ready <= 1'b1;
      2'd1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      2'd2: begin
        if (stall_left > 0) begin
          stall_left--;
          rsp_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
          stall_left = $urandom_range(1, 8);
          rsp_ch.ready <= 1'b0;
        end else begin
          rsp_ch.ready <= 1'b1;
        end
      end
      default: rsp_ch.ready <= $urandom_range(0, 1);
    endcase
  end

  // Watchdog: a run of cycles with no transfer anywhere means the block hung.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d decodes outstanding",
                 quiet_cycles, decode_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Drive one config write; the sender runs in bursts with random gaps. valid
  // stays high from one transfer to the next inside a burst.
  task automatic push_write(input logic [OFFSET_W-1:0] off, input logic [DATA_W-1:0] wd,
                            input logic [LEN_W-1:0] len, input plan_t how);
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    row_plan_q.push_back(how);
    req_ch.valid <= 1'b1;
    req_ch.cfg_offset <= off;
    req_ch.write_data <= wd;
    req_ch.access_bytes <= len;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Mostly BAR/ROM programming and command updates with legal lengths; about a
  // fifth is noise over the whole offset and length range.
  task automatic push_random();
    logic [OFFSET_W-1:0] off;
    logic [LEN_W-1:0] len;
    int unsigned pick;
    int unsigned s;
    plan_t how;
    how = '0;
    how.chk = BY_MODEL;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: len = 3'd1;
      1: len = 3'd2;
      default: len = 3'd4;
    endcase
    if (pick < 60) begin
      s = $urandom_range(0, NUM_REGIONS - 1);
      off = (s == ROM_SLOT) ? BAR0_OFFSET + 8'({ROM_DWORD, 2'b00}) : BAR0_OFFSET + 8'(4 * s);
      if (len == 3'd1) off = off + 8'($urandom_range(0, 3));
      else if (len == 3'd2) off = off + 8'(2 * $urandom_range(0, 1));
    end else if (pick < 80) begin
      off = CMD_OFFSET;
    end else begin
      off = 8'($urandom_range(0, 255));
      len = 3'($urandom_range(0, 7));
    end
    push_write(off, $urandom, len, how);
  endtask

  // Both registers in back-to-back transfers; only called while the block is idle.
  task automatic set_regs(input logic [KINDS_W-1:0] kinds, input logic [SIZES_W-1:0] sizes);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_BAR_KINDS;
    cfg_ch.data <= CFG_DATA_W'(kinds);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= REG_BAR_SIZES;
    cfg_ch.data <= CFG_DATA_W'(sizes);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // Let the last transfer be booked first, then wait for every owed decode, then give
  // writes that decode nothing time to leave the pipeline.
  task automatic settle();
    @(posedge clk);
    while (decode_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SIZES_W-1:0] rand_sizes(input int unsigned lo, input int unsigned hi);
    logic [SIZES_W-1:0] v;
    v = '0;
    for (int k = 0; k < NUM_REGIONS; k++) v[LG_W*k +: LG_W] = LG_W'($urandom_range(lo, hi));
    return v;
  endfunction

  initial begin
    logic [KINDS_W-1:0] kinds;
    logic [SIZES_W-1:0] sizes;
    int unsigned quota;
    int unsigned start;
    plan_t how;

    req_ch.valid = 1'b0;
    req_ch.cfg_offset = '0;
    req_ch.write_data = '0;
    req_ch.access_bytes = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pass over the table.
    set_regs({KIND_MEM64, KIND_ALIAS, KIND_IO, KIND_MEM32, KIND_MEM64, KIND_MEM32},
             {6'd11, 6'd1, 6'd63, 6'd8, 6'd4, 6'd20, 6'd12});
    foreach (STIM_TABLE[k]) begin
      how.chk = STIM_TABLE[k].chk;
      how.res.idx = STIM_TABLE[k].idx;
      how.res.mapped = STIM_TABLE[k].mapped;
      how.res.base = STIM_TABLE[k].base;
      how.res.changed = STIM_TABLE[k].changed;
      how.res.bme = STIM_TABLE[k].bme;
      how.res.last = 1'b1;
      push_write(STIM_TABLE[k].off, STIM_TABLE[k].data, STIM_TABLE[k].len, how);
    end
    req_ch.valid <= 1'b0;
    burst_left = 0;
    settle();

    // Random phases, each under its own register setting. Only writes that
    // reach the command or a slot count toward a phase's length.
    for (int p = 1; p <= 6; p++) begin
      case (p)
        1: begin kinds = KINDS_W'($urandom); sizes = rand_sizes(1, 40); quota = 45; end
        2: begin kinds = '1; sizes = '1; quota = 40; end
        3: begin kinds = '0; sizes = '0; quota = 15; end
        4: begin kinds = {6{KIND_MEM64}}; sizes = rand_sizes(0, 32); quota = 45; end
        5: begin kinds = {6{KIND_IO}}; sizes = rand_sizes(0, 16); quota = 40; end
        default: begin
          kinds = KINDS_W'($urandom);
          sizes = SIZES_W'({$urandom, $urandom});
          quota = 45;
        end
      endcase
      set_regs(kinds, sizes);
      start = writes_hit;
      while (writes_hit - start < quota) push_random();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      settle();
    end

    if (decode_q.size() != 0) begin
      $error("%0d decodes never arrived", decode_q.size());
      fails++;
    end
    $display("covered %0d config writes (%0d reached command or a slot) under %0d settings",
             writes_taken, writes_hit, settings_used);
    $display("checked %0d decode transfers, %0d mismatching", decodes_seen, fails);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
